>>> hdl/lifo_cap_pkg.sv
// ----------------------------------------------------------------------------
// lifo_cap_pkg
// Shared types and constants for the word stack with a resizing capacity.
// ----------------------------------------------------------------------------
package lifo_cap_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned DefWidth = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RESIZED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMEM   = 2'd3
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] pop_value;
    logic [10:0] fill_count;
    logic [10:0] capacity_now;
  } result_t;

endpackage

>>> hdl/lifo_stack_with_capacity_policy_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_capacity_policy_top
// Word stack with fill count and a logical capacity that grows on a full push
// and shrinks on a sparse pop. A push that must grow past DEPTH is refused.
// A beat is registered in item_q; its result in done_q, status_q and rdata_q.
// Throughput: one beat per cycle, busy is never raised.
// The result stage waits on the registered read port of the word store.
// Reset clears fill, capacity, minimum capacity and the pipeline valids;
// the word store is left unset and needs no clearing pass.
// ----------------------------------------------------------------------------
module lifo_stack_with_capacity_policy_top
  import lifo_cap_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ((FW > 11) ? FW : 11) + 1;
  localparam int unsigned MW = (WIDTH > 32) ? WIDTH : 32;

  logic [WIDTH-1:0] mem [DEPTH];

  logic          item_vld_q;
  cmd_t          item_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] cap_q, cap_d;
  logic [10:0]   min_cap_q;
  logic          done_q;
  status_e       status_q, status_d;
  logic          pop_flag_q, pop_flag_d;
  logic [WIDTH-1:0] rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [MW-1:0] wr_ext, rd_ext;
  logic [FW-1:0] fill_dec, shrink_lvl;
  logic [FW:0]   grown;

  assign busy = 1'b0;

  assign fill_dec   = fill_q - FW'(1);
  assign shrink_lvl = (cap_q - FW'(3)) >> 2;
  assign grown      = {cap_q, 1'b1};
  assign wr_ext     = MW'(item_q.push_value);

  always_comb begin
    fill_d     = fill_q;
    cap_d      = cap_q;
    status_d   = ST_OK;
    pop_flag_d = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = fill_q[AW-1:0];
    if (item_vld_q) begin
      if (item_q.opcode == OP_PUSH) begin
        if (fill_q >= cap_q) begin
          if (grown > (FW+1)'(DEPTH)) begin
            status_d = ST_NOMEM;
          end else begin
            cap_d    = grown[FW-1:0];
            status_d = ST_RESIZED;
          end
        end
        if (status_d != ST_NOMEM && fill_q < FW'(DEPTH)) begin
          mem_we = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end else begin
        if (fill_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          fill_d     = fill_dec;
          mem_re     = 1'b1;
          mem_addr   = fill_dec[AW-1:0];
          pop_flag_d = 1'b1;
          if (cap_q >= FW'(3) && fill_dec == shrink_lvl &&
              CW'(fill_dec) >= CW'(min_cap_q)) begin
            cap_d    = (cap_q - FW'(1)) >> 1;
            status_d = ST_RESIZED;
          end
        end
      end
    end
  end

  // word store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_ext[WIDTH-1:0];
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= cmd_i;
    end
    status_q   <= status_d;
    pop_flag_q <= pop_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      done_q     <= 1'b0;
      fill_q     <= '0;
      cap_q      <= '0;
      min_cap_q  <= '0;
    end else begin
      item_vld_q <= start && !busy;
      done_q     <= item_vld_q;
      if (cfg_we_i) begin
        min_cap_q <= cfg_wdata_i;
        fill_q    <= '0;
        cap_q     <= (CW'(cfg_wdata_i) > CW'(DEPTH)) ? FW'(DEPTH) : FW'(cfg_wdata_i);
      end else begin
        fill_q <= fill_d;
        cap_q  <= cap_d;
      end
    end
  end

  assign rd_ext = MW'(rdata_q);

  assign done_o                = done_q;
  assign result_o.status       = status_q;
  assign result_o.pop_value    = pop_flag_q ? rd_ext[31:0] : 32'd0;
  assign result_o.fill_count   = 11'(fill_q);
  assign result_o.capacity_now = 11'(cap_q);

endmodule

>>> hdl/lifo_cap_checker.sv
// ----------------------------------------------------------------------------
// lifo_cap_checker
// Port-level checks on beat timing and result consistency of the stack.
// ----------------------------------------------------------------------------
module lifo_cap_checker
  import lifo_cap_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input result_t     result_o
);

  // every accepted beat is followed by a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("result missing after accepted beat");

  // no result without an earlier accepted beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  // empty pop leaves an empty stack and returns zero
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_EMPTY |->
      result_o.fill_count == 11'd0 && result_o.pop_value == 32'd0)
    else $error("empty pop with words or data");

  // refused push returns no data
  a_nomem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_NOMEM |-> result_o.pop_value == 32'd0)
    else $error("refused push with data");

  // fill never passes the logical capacity
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.fill_count <= result_o.capacity_now)
    else $error("fill above capacity");

endmodule

bind lifo_stack_with_capacity_policy_top lifo_cap_checker u_lifo_cap_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

>>> test/lifo_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_checker
// Watches the command, result and register channels of the word stack. Keeps
// its own copy of the store, fill, capacity and minimum capacity, works out
// the result of every accepted command beat and compares each result beat
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lifo_stack_checker
  import lifo_cap_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_t        cmd_i,
  input  logic        done_i,
  input  result_t     result_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned resized_o,
  output int unsigned empty_o,
  output int unsigned nomem_o
);

  logic [31:0] word_mem [DEPTH];
  int unsigned fill_q;
  int unsigned cap_q;
  int unsigned min_cap_q;
  result_t     stack_results_q [$];

  function automatic result_t step_stack(cmd_t c);
    result_t     r;
    int unsigned grown;
    bit          refused;
    r         = '0;
    r.status  = ST_OK;
    refused   = 1'b0;
    if (c.opcode == OP_PUSH) begin
      if (fill_q >= cap_q) begin
        grown = cap_q * 2 + 1;
        if (grown > DEPTH) begin
          refused  = 1'b1;
          r.status = ST_NOMEM;
        end else begin
          cap_q    = grown;
          r.status = ST_RESIZED;
        end
      end
      if (!refused && fill_q < DEPTH) begin
        word_mem[fill_q] = c.push_value;
        fill_q++;
      end
    end else if (fill_q == 0) begin
      r.status = ST_EMPTY;
    end else begin
      fill_q--;
      r.pop_value = word_mem[fill_q];
      // shrink once the stack is down to a quarter of the capacity
      if (cap_q >= 3 && fill_q == (cap_q - 3) / 4 && fill_q >= min_cap_q) begin
        cap_q    = (cap_q - 1) / 2;
        r.status = ST_RESIZED;
      end
    end
    r.fill_count   = fill_q[10:0];
    r.capacity_now = cap_q[10:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_cnt_o++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      fill_q     = 0;
      cap_q      = 0;
      min_cap_q  = 0;
      fail_cnt_o = 0;
      resized_o  = 0;
      empty_o    = 0;
      nomem_o    = 0;
      stack_results_q.delete();
    end else begin
      if (done_i) begin
        if (stack_results_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t ns: result beat with nothing expected, expected none, actual %p",
                   $time, result_i);
        end else begin
          want = stack_results_q.pop_front();
          check_field("status", 32'(want.status), 32'(result_i.status));
          check_field("pop_value", want.pop_value, result_i.pop_value);
          check_field("fill_count", 32'(want.fill_count), 32'(result_i.fill_count));
          check_field("capacity_now", 32'(want.capacity_now), 32'(result_i.capacity_now));
        end
        case (result_i.status)
          ST_RESIZED: resized_o++;
          ST_EMPTY:   empty_o++;
          ST_NOMEM:   nomem_o++;
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        min_cap_q = cfg_wdata_i;
        cap_q     = (min_cap_q > DEPTH) ? DEPTH : min_cap_q;
        fill_q    = 0;
      end
      if (start_i && !busy_i) begin
        stack_results_q.push_back(step_stack(cmd_i));
      end
    end
    pending_o = stack_results_q.size();
  end

endmodule

>>> test/tb_lifo_stack_with_capacity_policy_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_capacity_policy_top
// Drives push and pop beats into the word stack under a range of minimum
// capacities: a directed opening, random push and pop bursts with random
// sender gaps, and a deep fill that runs into refused pushes. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_capacity_policy_top;
  import lifo_cap_pkg::*;

  localparam int unsigned DEPTH        = DefDepth;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 300;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  result_t     result;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  int unsigned cycle_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned settings_cnt = 0;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned resized_cnt;
  int unsigned empty_cnt;
  int unsigned nomem_cnt;
  bit          idle_on;

  lifo_stack_with_capacity_policy_top #(
    .DEPTH(DEPTH),
    .WIDTH(DefWidth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  lifo_stack_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .done_i     (done),
    .result_i   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt),
    .resized_o  (resized_cnt),
    .empty_o    (empty_cnt),
    .nomem_o    (nomem_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t ns: run stopped at cycle limit", $time);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_beat(input logic op, input logic [31:0] word);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{opcode: op, push_value: word};
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_min_cap(input logic [10:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_cnt++;
  endtask

  task automatic push_pop(input int unsigned pushes, input int unsigned pops);
    repeat (pushes) send_beat(OP_PUSH, pick_word());
    repeat (pops) send_beat(OP_POP, pick_word());
  endtask

  task automatic run_bursts(input int unsigned beats, input bit pause_midway);
    int unsigned stop_at;
    int unsigned k;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if (pause_midway && beats_sent >= stop_at - beats / 2) begin
        drain();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(1, 24);
        push_pop(k, $urandom_range(1, k + 2));
      end else begin
        repeat ($urandom_range(1, 6)) send_beat(logic'($urandom_range(0, 1)), pick_word());
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned random_end;
    logic [10:0] min_cap;
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    idle_on   = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: pop empty, grow 0 to 1 to 3 to 7, shrink back on pops
    send_beat(OP_POP, 32'h1234_5678);
    send_beat(OP_PUSH, 32'h0000_0000);
    send_beat(OP_PUSH, 32'hFFFF_FFFF);
    send_beat(OP_PUSH, 32'h5555_5555);
    send_beat(OP_PUSH, 32'hAAAA_AAAA);
    repeat (5) send_beat(OP_POP, 32'hFFFF_FFFF);
    write_min_cap(11'd2);
    push_pop(3, 3);
    write_min_cap(11'd1024);
    push_pop(2, 1);
    // above the store depth, capacity saturates
    write_min_cap(11'h7FF);
    push_pop(2, 2);
    write_min_cap(11'd1);
    push_pop(1, 1);

    phase      = 0;
    random_end = beats_sent + RANDOM_BEATS;
    while (beats_sent < random_end) begin
      case (phase % 8)
        0:       min_cap = 11'd0;
        1:       min_cap = 11'd1;
        2:       min_cap = 11'd2;
        3:       min_cap = 11'd3;
        4:       min_cap = 11'd5;
        5:       min_cap = 11'd7;
        6:       min_cap = 11'd15;
        default: min_cap = 11'($urandom_range(0, 40));
      endcase
      idle_on = (phase != 2);
      write_min_cap(min_cap);
      run_bursts(45, phase == 4);
      phase++;
    end
    idle_on = 1'b1;

    // deep fill: growth from 512 would pass the depth
    write_min_cap(11'd512);
    push_pop(512, 0);
    push_pop(3, 6);

    drain();
    $display("%0d beats over %0d capacity settings, %0d results outstanding",
             beats_sent, settings_cnt, pending_cnt);
    $display("%0d resizes, %0d empty pops, %0d refused pushes, %0d mismatches",
             resized_cnt, empty_cnt, nomem_cnt, fail_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lifo_cap_pkg.sv
hdl/lifo_stack_with_capacity_policy_top.sv
hdl/lifo_cap_checker.sv
test/lifo_stack_checker.sv
test/tb_lifo_stack_with_capacity_policy_top.sv
